// ===== hw/rtl/msh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mid-square hash table package
// Field widths, command and status codes and sequencer constants.
// ----------------------------------------------------------------------------
package msh_pkg;

	localparam int CMD_W = 2;
	localparam int KEY_W = 30;
	localparam int SLOT_W = 14;
	localparam int STATUS_W = 2;

	localparam int TABLE_SLOTS_DEF = 10000;

	localparam int ENTRY_W = KEY_W + 1;
	localparam int SQ_W = 2 * KEY_W;
	localparam int SQ_CNT_W = $clog2(SQ_W);
	localparam int BCD_DIGITS = 11;
	localparam int BCD_W = 4 * BCD_DIGITS;
	localparam int HOME_DIGIT_LO = 7;

	localparam int DEC_THOUSAND = 1000;
	localparam int DEC_HUNDRED = 100;
	localparam int DEC_TEN = 10;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

endpackage

// ===== hw/rtl/msh_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mid-square hash table channels
// Command channel (cmd, key) and result channel (slot, status).
// ----------------------------------------------------------------------------
interface msh_req_if;
	logic                         valid;
	logic                         ready;
	logic [msh_pkg::CMD_W-1:0]    cmd;
	logic [msh_pkg::KEY_W-1:0]    key;

	modport source (output valid, output cmd, output key, input ready);
	modport sink (input valid, input cmd, input key, output ready);
endinterface

interface msh_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [msh_pkg::SLOT_W-1:0]   slot;
	logic [msh_pkg::STATUS_W-1:0] status;

	modport source (output valid, output slot, output status, input ready);
	modport sink (input valid, input slot, input status, output ready);
endinterface

// ===== hw/rtl/mid_square_hash_probe_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mid-square hash probe table
// Open-addressing key table with a mid-square home slot and linear probing.
//
//   channel  dir  payload        transfer
//   req      in   cmd, key       req.valid && req.ready
//   rsp      out  slot, status   rsp.valid && rsp.ready
//
// One command is in flight at a time; req.ready is high only when idle.
// Insert: square the key, convert it to decimal and form the home slot, then
// read and check each probed slot in turn and load the result register.
// Search: scan the slots in turn from slot 0. Clear: a pass over every slot.
// After reset a clearing pass over all TABLE_SLOTS slots runs before req.ready.
// The result register frees the engine while rsp is stalled.
// ----------------------------------------------------------------------------
module mid_square_hash_probe_table #(
	parameter int TABLE_SLOTS = msh_pkg::TABLE_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	msh_req_if.sink   req,
	msh_rsp_if.source rsp
);
	import msh_pkg::*;

	localparam int AW = $clog2(TABLE_SLOTS);
	localparam int CW = $clog2(TABLE_SLOTS + 1);

	typedef enum logic [2:0] {
		S_WIPE, S_IDLE, S_SQUARE, S_DIGITS, S_HOME, S_RD, S_CHK, S_RESP
	} state_t;

	state_t                state_q;
	logic [CMD_W-1:0]      cmd_q;
	logic [KEY_W-1:0]      key_q;
	logic [SQ_W-1:0]       sq_q;
	logic [SQ_CNT_W-1:0]   sq_cnt_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [AW-1:0]         pos_q;
	logic [CW-1:0]         cnt_q;
	logic                  wipe_resp_q;
	logic [SLOT_W-1:0]     res_slot_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic                  out_valid_q;
	logic [SLOT_W-1:0]     out_slot_q;
	logic [STATUS_W-1:0]   out_status_q;

	logic [ENTRY_W-1:0]    mem [TABLE_SLOTS];
	logic [ENTRY_W-1:0]    rd_q;
	logic                  we;
	logic [ENTRY_W-1:0]    wdata;

	logic [SQ_W-1:0]       prod;
	logic [BCD_W-1:0]      bcd_adj;
	logic [BCD_W-1:0]      bcd_nxt;
	logic [CW-1:0]         home_raw;
	logic [CW-1:0]         home_red;
	logic [CW-1:0]         cnt_nxt;
	logic [AW-1:0]         pos_nxt;
	logic                  probe_last;
	logic                  hit;
	logic                  empty;
	logic                  out_free;

	assign prod = key_q * key_q;

	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	assign bcd_nxt = {bcd_adj[BCD_W-2:0], sq_q[SQ_W-1]};

	assign home_raw = CW'(bcd_q[4*HOME_DIGIT_LO +: 4]) * CW'(DEC_THOUSAND)
		+ CW'(bcd_q[4*(HOME_DIGIT_LO+1) +: 4]) * CW'(DEC_HUNDRED)
		+ CW'(bcd_q[4*(HOME_DIGIT_LO+2) +: 4]) * CW'(DEC_TEN)
		+ CW'(bcd_q[4*(HOME_DIGIT_LO+3) +: 4]);
	assign home_red = (home_raw >= CW'(TABLE_SLOTS)) ? home_raw - CW'(TABLE_SLOTS) : home_raw;

	assign cnt_nxt = cnt_q + CW'(1);
	assign probe_last = (cnt_nxt == CW'(TABLE_SLOTS));
	assign pos_nxt = (pos_q == AW'(TABLE_SLOTS - 1)) ? '0 : pos_q + AW'(1);
	assign empty = !rd_q[ENTRY_W-1];
	assign hit = (rd_q == {1'b1, key_q});
	assign out_free = !out_valid_q || rsp.ready;

	always_comb begin
		we = 1'b0;
		wdata = '0;
		if (state_q == S_WIPE) begin
			we = 1'b1;
		end else if (state_q == S_CHK && cmd_q == CMD_INSERT && empty) begin
			we = 1'b1;
			wdata = {1'b1, key_q};
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[pos_q] <= wdata;
		end
		rd_q <= mem[pos_q];
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.slot = out_slot_q;
	assign rsp.status = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_WIPE;
			cmd_q <= CMD_CLEAR;
			key_q <= '0;
			sq_q <= '0;
			sq_cnt_q <= '0;
			bcd_q <= '0;
			pos_q <= '0;
			cnt_q <= '0;
			wipe_resp_q <= 1'b0;
			res_slot_q <= '0;
			res_status_q <= ST_OK;
			out_valid_q <= 1'b0;
			out_slot_q <= '0;
			out_status_q <= ST_OK;
		end else begin
			if (rsp.ready && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_WIPE: begin
					if (pos_q == AW'(TABLE_SLOTS - 1)) begin
						pos_q <= '0;
						res_slot_q <= '0;
						res_status_q <= ST_OK;
						state_q <= wipe_resp_q ? S_RESP : S_IDLE;
					end else begin
						pos_q <= pos_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						cmd_q <= req.cmd;
						key_q <= req.key;
						pos_q <= '0;
						cnt_q <= '0;
						res_slot_q <= '0;
						res_status_q <= ST_OK;
						case (req.cmd)
							CMD_CLEAR: begin
								wipe_resp_q <= 1'b1;
								state_q <= S_WIPE;
							end
							CMD_INSERT: state_q <= S_SQUARE;
							CMD_SEARCH: state_q <= S_RD;
							default: state_q <= S_RESP;
						endcase
					end
				end
				S_SQUARE: begin
					sq_q <= prod;
					bcd_q <= '0;
					sq_cnt_q <= '0;
					state_q <= S_DIGITS;
				end
				S_DIGITS: begin
					bcd_q <= bcd_nxt;
					sq_q <= {sq_q[SQ_W-2:0], 1'b0};
					sq_cnt_q <= sq_cnt_q + SQ_CNT_W'(1);
					if (sq_cnt_q == SQ_CNT_W'(SQ_W - 1)) begin
						state_q <= S_HOME;
					end
				end
				S_HOME: begin
					pos_q <= AW'(home_red);
					cnt_q <= '0;
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if ((cmd_q == CMD_INSERT && empty) || (cmd_q == CMD_SEARCH && hit)) begin
						res_slot_q <= SLOT_W'(pos_q);
						res_status_q <= ST_OK;
						state_q <= S_RESP;
					end else if (probe_last) begin
						res_slot_q <= '0;
						res_status_q <= (cmd_q == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
						state_q <= S_RESP;
					end else begin
						cnt_q <= cnt_nxt;
						pos_q <= pos_nxt;
						state_q <= S_RD;
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_slot_q <= res_slot_q;
						out_status_q <= res_status_q;
						wipe_resp_q <= 1'b0;
						pos_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_write_only_wipe_or_probe: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == S_WIPE || state_q == S_CHK))
		else $error("Table written outside the clearing pass or a probe.");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q != S_IDLE))
		else $error("Engine idle right after a command transfer.");

	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK) |-> (cnt_q < CW'(TABLE_SLOTS) && pos_q <= AW'(TABLE_SLOTS - 1)))
		else $error("Probe position or count out of range.");

	a_result_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_RESP))
		else $error("Result loaded outside the response state.");

endmodule
